@@ sv/ppt_pkg.sv @@
// shared widths, types and codes for the projective point transform
package ppt_pkg;

  // fixed point formats
  localparam int CoordW   = 32;  // Q16.16 coordinates
  localparam int CoefW    = 16;  // Q4.12 coefficients
  localparam int FracW    = 16;  // fraction bits of a coordinate
  localparam int NumTerms = 3;   // x, y, z terms of a row
  localparam int ProdW    = CoefW + CoordW;
  localparam int SumW     = ProdW + 1;
  localparam int MagW     = ProdW;
  localparam int QuotW    = CoordW;
  localparam int NumRows  = 4;
  localparam int NumLanes = 3;

  // configuration port
  localparam int CfgW    = NumRows * CoefW;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_ROW_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_W = 3'd3;

  // row positions
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  // clip values
  localparam logic [QuotW-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [QuotW-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [QuotW-1:0]         quot_t;
  typedef logic [CfgW-1:0]          row_t;

  // partial remainder and dividend/quotient shift word of one lane
  typedef struct packed {
    mag_t  rem;
    quot_t work;
  } div_lane_t;

  // per item control that travels with the divider lanes
  typedef struct packed {
    mag_t                den;
    logic                zero;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
  } div_ctl_t;

endpackage

@@ sv/ppt_dot.sv @@
// four row dot products of a homogeneous point, three register stages
module ppt_dot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ppt_pkg::coord_t x_i,
  input  ppt_pkg::coord_t y_i,
  input  ppt_pkg::coord_t z_i,
  input  ppt_pkg::row_t   row_i [ppt_pkg::NumRows],
  output logic            valid_o,
  output ppt_pkg::sum_t   sum_o [ppt_pkg::NumRows]
);
  import ppt_pkg::*;

  coord_t pt [NumTerms];
  prod_t  prod_d  [NumRows][NumTerms];
  prod_t  prod_q  [NumRows][NumTerms];
  prod_t  shift_d [NumRows];
  prod_t  shift_q [NumRows];
  sum_t   pair_a_d [NumRows];
  sum_t   pair_a_q [NumRows];
  sum_t   pair_b_d [NumRows];
  sum_t   pair_b_q [NumRows];
  sum_t   sum_d [NumRows];
  sum_t   sum_q [NumRows];
  logic   prod_v_q, pair_v_q, sum_v_q;

  // coefficient times coordinate products, translation scaled to Q.28
  always_comb begin
    pt[0] = x_i;
    pt[1] = y_i;
    pt[2] = z_i;
    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < NumTerms; k++) begin
        prod_d[r][k] = prod_t'(signed'(row_i[r][k*CoefW +: CoefW])) * prod_t'(pt[k]);
      end
      shift_d[r] = ProdW'(signed'({row_i[r][NumTerms*CoefW +: CoefW], {FracW{1'b0}}}));
    end
  end

  // pairwise sums, then the row total
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      pair_a_d[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]);
      pair_b_d[r] = SumW'(prod_q[r][2]) + SumW'(shift_q[r]);
      sum_d[r]    = pair_a_q[r] + pair_b_q[r];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    shift_q  <= shift_d;
    pair_a_q <= pair_a_d;
    pair_b_q <= pair_b_d;
    sum_q    <= sum_d;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      pair_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
    end else begin
      prod_v_q <= valid_i;
      pair_v_q <= prod_v_q;
      sum_v_q  <= pair_v_q;
    end
  end

  assign valid_o = sum_v_q;
  assign sum_o   = sum_q;

endmodule

@@ sv/ppt_div_step.sv @@
// one restoring division step for all lanes, one quotient bit per lane
module ppt_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ppt_pkg::div_ctl_t   ctl_i,
  input  ppt_pkg::div_lane_t  lane_i [ppt_pkg::NumLanes],
  output logic                valid_o,
  output ppt_pkg::div_ctl_t   ctl_o,
  output ppt_pkg::div_lane_t  lane_o [ppt_pkg::NumLanes]
);
  import ppt_pkg::*;

  logic [MagW:0]       trial [NumLanes];
  logic [MagW:0]       diff  [NumLanes];
  logic [NumLanes-1:0] ge;
  div_lane_t           lane_d [NumLanes];
  div_lane_t           lane_q [NumLanes];
  div_ctl_t            ctl_q;
  logic                valid_q;

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      trial[l] = {lane_i[l].rem, lane_i[l].work[QuotW-1]};
      diff[l]  = trial[l] - {1'b0, ctl_i.den};
      ge[l]    = (trial[l] >= {1'b0, ctl_i.den});
      lane_d[l].rem  = ge[l] ? diff[l][MagW-1:0] : trial[l][MagW-1:0];
      lane_d[l].work = {lane_i[l].work[QuotW-2:0], ge[l]};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    ctl_q  <= ctl_i;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign lane_o  = lane_q;

endmodule

@@ sv/ppt_div.sv @@
// pipelined magnitude divider: Q16.16 quotients of three numerators by one divisor
module ppt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ppt_pkg::mag_t                   num_i [ppt_pkg::NumLanes],
  input  ppt_pkg::mag_t                   den_i,
  input  logic                            zero_i,
  input  logic [ppt_pkg::NumLanes-1:0]    neg_i,
  output logic                            valid_o,
  output ppt_pkg::quot_t                  quot_o [ppt_pkg::NumLanes],
  output ppt_pkg::div_ctl_t               ctl_o
);
  import ppt_pkg::*;

  mag_t                hi [NumLanes];
  logic [NumLanes-1:0] ovf;
  div_lane_t           lane0_d [NumLanes];
  div_lane_t           lane0_q [NumLanes];
  div_ctl_t            ctl0_d;
  div_ctl_t            ctl0_q;
  logic                valid0_q;

  logic                valid_s [QuotW+1];
  div_ctl_t            ctl_s   [QuotW+1];
  div_lane_t           lane_s  [QuotW+1][NumLanes];

  // numerator scaled by 2^16: upper word seeds the remainder, the rest shifts in
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      hi[l]  = MagW'(num_i[l][MagW-1:FracW]);
      ovf[l] = (hi[l] >= den_i);
      lane0_d[l].rem  = hi[l];
      lane0_d[l].work = {num_i[l][FracW-1:0], {(QuotW-FracW){1'b0}}};
    end
    ctl0_d.den  = den_i;
    ctl0_d.zero = zero_i;
    ctl0_d.neg  = neg_i;
    ctl0_d.ovf  = ovf;
  end

  // setup stage payload
  always_ff @(posedge clk_i) begin
    lane0_q <= lane0_d;
    ctl0_q  <= ctl0_d;
  end

  // setup stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= valid_i;
    end
  end

  assign lane_s[0]  = lane0_q;
  assign ctl_s[0]   = ctl0_q;
  assign valid_s[0] = valid0_q;

  // one stage per quotient bit
  for (genvar i = 0; i < QuotW; i++) begin : g_step
    ppt_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ctl_i   (ctl_s[i]),
      .lane_i  (lane_s[i]),
      .valid_o (valid_s[i+1]),
      .ctl_o   (ctl_s[i+1]),
      .lane_o  (lane_s[i+1])
    );
  end

  // finished quotients
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      quot_o[l] = lane_s[QuotW][l].work;
    end
  end

  assign valid_o = valid_s[QuotW];
  assign ctl_o   = ctl_s[QuotW];

endmodule

@@ sv/projective_point_transform.sv @@
// top level of the homogeneous 4x4 point transform with perspective divide
//
// A point (in_x_i, in_y_i, in_z_i, signed Q16.16) is taken as a transaction
// at a rising edge with start high and busy low. busy stays low: a new point
// may be issued in every cycle and the pipeline holds up to 38 of them.
// The point is extended with w = 1, multiplied by the four matrix rows and
// the x, y and z results are divided by the w result, truncated toward zero.
// Each result appears on out_*_o with done_o high for exactly one cycle;
// the edge that ends that cycle takes it and the receiver cannot hold it off.
// From the accepting edge a point passes the multiply and adder tree, the
// magnitude stage, divider setup, the one bit per stage divider and clipping.
// Throughput is one point per cycle in steady state.
// Matrix rows are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
// 64 bit row of four Q4.12 coefficients per write; the user must write them
// only while no point is in flight, as the block does not enforce this;
// indexes beyond the four rows are ignored.
// Reset clears the rows and all valid bits; points in flight are dropped.
module projective_point_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ppt_pkg::coord_t               in_x_i,
  input  ppt_pkg::coord_t               in_y_i,
  input  ppt_pkg::coord_t               in_z_i,
  input  logic                          cfg_we_i,
  input  logic [ppt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppt_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                          done_o,
  output ppt_pkg::coord_t               out_x_o,
  output ppt_pkg::coord_t               out_y_o,
  output ppt_pkg::coord_t               out_z_o,
  output logic                          zero_divisor_o,
  output logic                          saturated_o
);
  import ppt_pkg::*;

  row_t                row_d [NumRows];
  row_t                row_q [NumRows];
  logic                accept;

  logic                dot_v;
  sum_t                dot_sum [NumRows];

  sum_t                abs_v  [NumRows];
  mag_t                mag_d  [NumRows];
  mag_t                mag_q  [NumRows];
  logic [NumRows-1:0]  sign_d, sign_q;
  logic                zero_d, zero_q;
  logic                mag_v_q;

  mag_t                num_s [NumLanes];
  logic [NumLanes-1:0] neg_s;

  logic                div_v;
  quot_t               quot [NumLanes];
  div_ctl_t            div_ctl;

  quot_t               res_d [NumLanes];
  quot_t               res_q [NumLanes];
  logic [NumLanes-1:0] clip;
  logic                sat_d, sat_q;
  logic                zdiv_q;
  logic                done_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // matrix row writes
  always_comb begin
    row_d = row_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_X: row_d[ROW_X] = cfg_wdata_i;
        CFG_ROW_Y: row_d[ROW_Y] = cfg_wdata_i;
        CFG_ROW_Z: row_d[ROW_Z] = cfg_wdata_i;
        CFG_ROW_W: row_d[ROW_W] = cfg_wdata_i;
        default:   row_d = row_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        row_q[r] <= '0;
      end
    end else begin
      row_q <= row_d;
    end
  end

  // row dot products
  ppt_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (in_x_i),
    .y_i     (in_y_i),
    .z_i     (in_z_i),
    .row_i   (row_q),
    .valid_o (dot_v),
    .sum_o   (dot_sum)
  );

  // magnitudes, signs and the zero divisor check
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      abs_v[r]  = dot_sum[r][SumW-1] ? -dot_sum[r] : dot_sum[r];
      mag_d[r]  = abs_v[r][MagW-1:0];
      sign_d[r] = dot_sum[r][SumW-1];
    end
    zero_d = (dot_sum[ROW_W] == '0);
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    sign_q <= sign_d;
    zero_q <= zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_v_q <= 1'b0;
    end else begin
      mag_v_q <= dot_v;
    end
  end

  // numerators and quotient signs for the divider
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      num_s[l] = mag_q[l];
      neg_s[l] = sign_q[l] ^ sign_q[ROW_W];
    end
  end

  ppt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mag_v_q),
    .num_i   (num_s),
    .den_i   (mag_q[ROW_W]),
    .zero_i  (zero_q),
    .neg_i   (neg_s),
    .valid_o (div_v),
    .quot_o  (quot),
    .ctl_o   (div_ctl)
  );

  // apply sign, clip to Q16.16, force zeros on a zero divisor
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (div_ctl.neg[l]) begin
        clip[l]  = div_ctl.ovf[l] | (quot[l] > NEG_LIMIT);
        res_d[l] = clip[l] ? NEG_LIMIT : ('0 - quot[l]);
      end else begin
        clip[l]  = div_ctl.ovf[l] | quot[l][QuotW-1];
        res_d[l] = clip[l] ? POS_LIMIT : quot[l];
      end
      if (div_ctl.zero) begin
        res_d[l] = '0;
      end
    end
    sat_d = |clip & ~div_ctl.zero;
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    sat_q  <= sat_d;
    zdiv_q <= div_ctl.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_v;
    end
  end

  assign done_o         = done_q;
  assign out_x_o        = signed'(res_q[ROW_X]);
  assign out_y_o        = signed'(res_q[ROW_Y]);
  assign out_z_o        = signed'(res_q[ROW_Z]);
  assign zero_divisor_o = zdiv_q;
  assign saturated_o    = sat_q;

endmodule

@@ sv/ppt_checker.sv @@
// port level checks of the projective point transform, bound to the top level
module ppt_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input ppt_pkg::coord_t out_x_o,
  input ppt_pkg::coord_t out_y_o,
  input ppt_pkg::coord_t out_z_o,
  input logic            zero_divisor_o,
  input logic            saturated_o
);
  import ppt_pkg::*;

  // multiply tree, magnitude, divider setup, quotient bits, clip stage
  localparam int Latency = 3 + 1 + 1 + QuotW + 1;

  // every transaction yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o)
    else $error("result missing after fixed latency");

  // the block never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // zero divisor gives zero coordinates and no clip flag
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_divisor_o |->
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && !saturated_o)
    else $error("zero divisor result not cleared");

  // a clipped result carries at least one limit value
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      out_x_o == POS_LIMIT || out_x_o == NEG_LIMIT ||
      out_y_o == POS_LIMIT || out_y_o == NEG_LIMIT ||
      out_z_o == POS_LIMIT || out_z_o == NEG_LIMIT)
    else $error("saturated flag without a limit value");

endmodule

bind projective_point_transform ppt_checker u_ppt_checker (.*);

@@ tb/tb_projective_point_transform.sv @@
// testbench for the projective point transform: directed and random points checked against a predictor
`timescale 1ns / 100ps

module tb_projective_point_transform;
  import ppt_pkg::*;

  // highest index the config port can carry; indexes past the w row are spare
  localparam logic [CfgIdxW-1:0] CFG_IDX_LAST = '1;
  localparam int NumPhases      = 10;
  localparam int PointsPerPhase = 65;
  localparam int DrainCycles    = 48;

  // one entry of the feed: a row write or a point
  typedef struct packed {
    logic               is_row_write;
    logic [CfgIdxW-1:0] row_idx;
    row_t               row_val;
    coord_t             px;
    coord_t             py;
    coord_t             pz;
    logic [4:0]         idle_after;
  } feed_t;

  // one projected point as the block should deliver it
  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    logic   zero_div;
    logic   sat;
  } projection_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  coord_t             in_x_i      = '0;
  coord_t             in_y_i      = '0;
  coord_t             in_z_i      = '0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               done_o;
  coord_t             out_x_o;
  coord_t             out_y_o;
  coord_t             out_z_o;
  logic               zero_divisor_o;
  logic               saturated_o;

  feed_t       feed_q[$];
  projection_t projected_q[$];
  row_t        mat_rows[NumRows];
  logic        point_taken = 1'b0;
  logic        idle_enable = 1'b1;
  int unsigned idle_left   = 0;
  int unsigned error_count = 0;
  int unsigned results_seen = 0;

  projective_point_transform DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .in_z_i         (in_z_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .zero_divisor_o (zero_divisor_o),
    .saturated_o    (saturated_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // exact row dot product in Q.28, translation times w = 1
  function automatic longint row_sum(row_t row, coord_t x, coord_t y, coord_t z);
    longint cx, cy, cz, ct;
    cx = $signed(row[15:0]);
    cy = $signed(row[31:16]);
    cz = $signed(row[47:32]);
    ct = $signed(row[63:48]);
    return cx * x + cy * y + cz * z + ct * 65536;
  endfunction

  // num / den in Q16.16 truncated toward zero; msb is the clip flag
  function automatic logic [QuotW:0] scaled_quotient(longint num, longint den);
    longint unsigned n, d, q, r, m;
    logic neg;
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q   = n / d;
    r   = n % d;
    if (q >= 64'd65536) m = 64'd1 << 40;
    else m = (q << 16) + ((r << 16) / d);
    if (neg) begin
      if (m > 64'h8000_0000) return {1'b1, NEG_LIMIT};
      return {1'b0, quot_t'(64'd0 - m)};
    end
    if (m > 64'h7FFF_FFFF) return {1'b1, POS_LIMIT};
    return {1'b0, quot_t'(m)};
  endfunction

  // expected output for one point under the current matrix
  function automatic projection_t project_point(coord_t x, coord_t y, coord_t z);
    longint den;
    logic [QuotW:0] qx, qy, qz;
    projection_t res;
    res = '0;
    den = row_sum(mat_rows[ROW_W], x, y, z);
    if (den == 0) begin
      res.zero_div = 1'b1;
      return res;
    end
    qx = scaled_quotient(row_sum(mat_rows[ROW_X], x, y, z), den);
    qy = scaled_quotient(row_sum(mat_rows[ROW_Y], x, y, z), den);
    qz = scaled_quotient(row_sum(mat_rows[ROW_Z], x, y, z), den);
    res.ox  = qx[QuotW-1:0];
    res.oy  = qy[QuotW-1:0];
    res.oz  = qz[QuotW-1:0];
    res.sat = qx[QuotW] | qy[QuotW] | qz[QuotW];
    return res;
  endfunction

  // coordinate mix: full range, small, medium and corner values
  function automatic coord_t random_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5: begin
        v = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        return coord_t'(v);
      end
      6, 7: begin
        v = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        return coord_t'(v);
      end
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  // Q4.12 coefficient mix: full range, around one, small and corner values
  function automatic logic [CoefW-1:0] random_coef();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: return CoefW'($urandom);
      3, 4, 5: begin
        v = int'($urandom_range(0, 16'h4000)) - 16'h2000;
        return CoefW'(v);
      end
      6, 7: begin
        v = int'($urandom_range(0, 16'h0800)) - 16'h0400;
        return CoefW'(v);
      end
      default: begin
        case ($urandom_range(0, 6))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          4: return 16'hF000;
          5: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  function automatic row_t random_row();
    return {random_coef(), random_coef(), random_coef(), random_coef()};
  endfunction

  // typical perspective divisor: w = 1 + c * z
  function automatic row_t perspective_row();
    int v;
    v = int'($urandom_range(0, 16'h0400)) - 16'h0200;
    return {16'h1000, CoefW'(v), 16'h0000, 16'h0000};
  endfunction

  task automatic queue_row(input logic [CfgIdxW-1:0] idx, input row_t val);
    feed_t f;
    f = '0;
    f.is_row_write = 1'b1;
    f.row_idx      = idx;
    f.row_val      = val;
    feed_q.push_back(f);
  endtask

  task automatic queue_point(input coord_t x, input coord_t y, input coord_t z);
    feed_t f;
    f    = '0;
    f.px = x;
    f.py = y;
    f.pz = z;
    if (idle_enable && $urandom_range(0, 5) == 0) f.idle_after = 5'($urandom_range(1, 14));
    feed_q.push_back(f);
  endtask

  task automatic queue_matrix(input row_t rx, input row_t ry, input row_t rz, input row_t rw);
    queue_row(CFG_ROW_X, rx);
    queue_row(CFG_ROW_Y, ry);
    queue_row(CFG_ROW_Z, rz);
    queue_row(CFG_ROW_W, rw);
  endtask

  // driver: points go out back to back unless idling; row writes wait for an empty pipeline
  always @(negedge clk_i) begin : feed_driver
    logic  nxt_start;
    logic  nxt_we;
    feed_t head;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (start && point_taken) nxt_start = 1'b0;
    point_taken = 1'b0;
    if (rst_ni && !nxt_start) begin
      if (idle_left != 0) begin
        idle_left--;
      end else if (feed_q.size() != 0) begin
        head = feed_q[0];
        if (head.is_row_write) begin
          if (projected_q.size() == 0) begin
            void'(feed_q.pop_front());
            cfg_idx_i   <= head.row_idx;
            cfg_wdata_i <= head.row_val;
            nxt_we = 1'b1;
          end
        end else begin
          void'(feed_q.pop_front());
          in_x_i <= head.px;
          in_y_i <= head.py;
          in_z_i <= head.pz;
          nxt_start = 1'b1;
          idle_left = head.idle_after;
        end
      end
    end
    start    <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // monitor: track row writes, predict each accepted point, check each result
  always @(posedge clk_i) begin : result_monitor
    projection_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_X: mat_rows[ROW_X] = cfg_wdata_i;
          CFG_ROW_Y: mat_rows[ROW_Y] = cfg_wdata_i;
          CFG_ROW_Z: mat_rows[ROW_Z] = cfg_wdata_i;
          CFG_ROW_W: mat_rows[ROW_W] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start && busy === 1'b0) begin
        projected_q.push_back(project_point(in_x_i, in_y_i, in_z_i));
        point_taken = 1'b1;
      end
      if (done_o === 1'b1) begin
        results_seen++;
        if (projected_q.size() == 0) begin
          report_error($sformatf("result %0d with no point outstanding", results_seen));
        end else begin
          want = projected_q.pop_front();
          if (out_x_o !== want.ox)
            report_error($sformatf("result %0d out_x got %h want %h",
                                   results_seen, out_x_o, want.ox));
          if (out_y_o !== want.oy)
            report_error($sformatf("result %0d out_y got %h want %h",
                                   results_seen, out_y_o, want.oy));
          if (out_z_o !== want.oz)
            report_error($sformatf("result %0d out_z got %h want %h",
                                   results_seen, out_z_o, want.oz));
          if (zero_divisor_o !== want.zero_div)
            report_error($sformatf("result %0d zero_divisor got %b want %b",
                                   results_seen, zero_divisor_o, want.zero_div));
          if (saturated_o !== want.sat)
            report_error($sformatf("result %0d saturated got %b want %b",
                                   results_seen, saturated_o, want.sat));
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    row_t   rw;
    coord_t px;
    int     p, k, drain;
    foreach (mat_rows[i]) mat_rows[i] = '0;

    // rows still at reset: every point hits a zero divisor
    queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    // spare indexes must leave the matrix alone
    queue_row(CFG_ROW_W + 1'b1, '1);
    queue_row(CFG_IDX_LAST, row_t'({$urandom, $urandom}));
    queue_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

    // identity: exact limits pass through, most negative is not clipped
    queue_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                 64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);

    // large gains clip in both directions
    queue_row(CFG_ROW_X, 64'h0000_0000_0000_7FFF);
    queue_row(CFG_ROW_Y, 64'h0000_0000_8000_0000);
    queue_row(CFG_ROW_Z, 64'h7FFF_0000_0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    queue_point(32'h1000_0000, 32'h1000_0000, 32'h8000_0000);

    // tiny divisor amplifies
    queue_row(CFG_ROW_X, 64'h0000_0000_0000_1000);
    queue_row(CFG_ROW_W, 64'h0001_0000_0000_0000);
    queue_point(32'h0000_0010, 32'h0000_0000, 32'h0000_0000);
    queue_point(32'h0008_0000, 32'hFFF8_0000, 32'h0000_0000);

    // negative divisor flips signs
    queue_row(CFG_ROW_W, 64'h8000_0000_0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

    // divisor x - 1.0: cancels to zero at x = 1.0, tiny just above
    queue_row(CFG_ROW_W, 64'hF000_0000_0000_1000);
    queue_point(32'h0001_0000, 32'h0000_0005, 32'h0000_0007);
    queue_point(32'h0001_0001, 32'h0001_0000, 32'hFFFF_0000);
    queue_point(32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF);

    // most negative and most positive coefficients everywhere
    queue_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // all ones rows
    queue_matrix('1, '1, '1, '1);
    queue_point(32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    // random phases, each under its own matrix
    for (p = 0; p < NumPhases; p++) begin
      idle_enable = (p != 3) && (p != NumPhases - 1);
      case (p)
        0: queue_matrix(random_row(), random_row(), random_row(), '1);
        1: queue_matrix('0, '1, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF);
        2: queue_matrix(random_row(), random_row(), random_row(), perspective_row());
        4: queue_matrix(random_row(), random_row(), random_row(),
                        {random_coef(), 16'h0000, 16'h0000, 16'h1000});
        default: queue_matrix(random_row(), random_row(), random_row(),
                              p[0] ? perspective_row() : random_row());
      endcase
      rw = feed_q[feed_q.size() - 1].row_val;
      if ($urandom_range(0, 2) == 0)
        queue_row(CfgIdxW'($urandom_range(CFG_ROW_W + 1, CFG_IDX_LAST)),
                  row_t'({$urandom, $urandom}));
      for (k = 0; k < PointsPerPhase; k++) begin
        px = random_coord();
        // divisor x + t: pick x = -16 t so the divisor cancels
        if (p == 4 && $urandom_range(0, 4) == 0)
          px = -({{16{rw[63]}}, rw[63:48]} * 16);
        queue_point(px, random_coord(), random_coord());
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || start) @(posedge clk_i);
    for (drain = 0; drain < 200 && projected_q.size() != 0; drain++) @(posedge clk_i);
    if (projected_q.size() != 0)
      report_error($sformatf("%0d results never arrived", projected_q.size()));
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ppt_pkg.sv
sv/ppt_dot.sv
sv/ppt_div_step.sv
sv/ppt_div.sv
sv/projective_point_transform.sv
sv/ppt_checker.sv
tb/tb_projective_point_transform.sv
